// ===== rtl/batched_matrix_multiply_macros.svh =====
// Assertion macros for the batched matrix multiply block.
// BMM_ASSERT samples on aclk and is off while aresetn is low.
// BMM_ASSERT_ALWAYS samples on aclk, reset included.
`ifndef BATCHED_MATRIX_MULTIPLY_MACROS_SVH
`define BATCHED_MATRIX_MULTIPLY_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BMM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define BMM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define BMM_ASSERT(label, prop, msg)
`define BMM_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/bmm_pkg.sv =====
package bmm_pkg;

    localparam int MAX_DIM     = 16;
    localparam int MAX_BATCH   = 4;
    localparam int STORE_DEPTH = MAX_BATCH * MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int K_W         = $clog2(MAX_DIM);

    localparam int MODE_W      = 2;
    localparam int BATCH_W     = 2;
    localparam int IDX_W       = 4;
    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int ACC_W       = 36;

    localparam int DIM_REG_W   = 5;
    localparam int BATCH_REG_W = 3;

    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic [MODE_W-1:0] MODE_WR_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WR_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RD_C = 2'd2;

    localparam logic [1:0] REG_ROWS_A      = 2'd0;
    localparam logic [1:0] REG_INNER_LEN   = 2'd1;
    localparam logic [1:0] REG_COLS_B      = 2'd2;
    localparam logic [1:0] REG_BATCH_COUNT = 2'd3;

    typedef struct packed {
        logic clear;
        logic issue;
    } mac_ctrl_t;

    function automatic logic [ADDR_W-1:0] store_addr(
        input logic [BATCH_W-1:0] b,
        input logic [IDX_W-1:0]   r,
        input logic [IDX_W-1:0]   c
    );
        logic [31:0] idx;
        idx = 32'(b) * 32'(MAX_DIM * MAX_DIM) + 32'(r) * 32'(MAX_DIM) + 32'(c);
        return idx[ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/batched_matrix_multiply.sv =====
// In-range element writes are taken back to back.
// A product request walks its inner length K through the stores and the multiplier,
// one multiply-accumulate per cycle; the request port is busy until its result is loaded.
// An out-of-range request loads its flagged result through the finish state instead.
// Reset (aresetn low, synchronous) sets the sizes to 16x16x16 and one batch and
// empties the result register; the A and B stores are undefined until written.
`include "batched_matrix_multiply_macros.svh"

module batched_matrix_multiply
    import bmm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [MODE_W-1:0]        s_mode,
    input  logic [BATCH_W-1:0]       s_batch,
    input  logic [IDX_W-1:0]         s_row,
    input  logic [IDX_W-1:0]         s_col,
    input  logic signed [ELEM_W-1:0] s_value,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [ACC_W-1:0]  m_product,
    output logic                     m_range_error
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [DIM_REG_W-1:0]   rows_a_reg;
    logic [DIM_REG_W-1:0]   inner_len_reg;
    logic [DIM_REG_W-1:0]   cols_b_reg;
    logic [BATCH_REG_W-1:0] batch_count_reg;

    logic [1:0]             state_reg, state_next;
    logic [K_W-1:0]         k_reg, k_next;
    logic [ADDR_W-1:0]      a_addr_reg, a_addr_next;
    logic [ADDR_W-1:0]      b_addr_reg, b_addr_next;
    logic                   err_reg, err_next;

    logic                   m_valid_reg, m_valid_next;
    logic [ACC_W-1:0]       m_product_reg, m_product_next;
    logic                   m_range_error_reg, m_range_error_next;

    logic                   cfg_wr;
    logic [1:0]             cfg_idx;
    logic                   accept;
    logic [DIM_REG_W-1:0]   nk;
    logic                   batch_ok;
    logic                   row_in_r, row_in_k, col_in_k, col_in_c;
    logic                   ok_a, ok_b, ok_c;
    logic                   last_k;
    logic                   out_free;

    mac_ctrl_t              mac_ctrl;
    logic [ELEM_W-1:0]      a_rdata, b_rdata;
    logic [ACC_W-1:0]       mac_acc;
    logic                   mac_busy;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg      <= DIM_REG_W'(16);
            inner_len_reg   <= DIM_REG_W'(16);
            cols_b_reg      <= DIM_REG_W'(16);
            batch_count_reg <= BATCH_REG_W'(1);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ROWS_A:      rows_a_reg      <= pwdata[DIM_REG_W-1:0];
                REG_INNER_LEN:   inner_len_reg   <= pwdata[DIM_REG_W-1:0];
                REG_COLS_B:      cols_b_reg      <= pwdata[DIM_REG_W-1:0];
                REG_BATCH_COUNT: batch_count_reg <= pwdata[BATCH_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ROWS_A:      prdata = PDATA_W'(rows_a_reg);
            REG_INNER_LEN:   prdata = PDATA_W'(inner_len_reg);
            REG_COLS_B:      prdata = PDATA_W'(cols_b_reg);
            REG_BATCH_COUNT: prdata = PDATA_W'(batch_count_reg);
            default:         prdata = '0;
        endcase
    end

    // range checks, sizes saturate at the store dimensions
    assign nk = (32'(inner_len_reg) > 32'(MAX_DIM)) ? DIM_REG_W'(MAX_DIM) : inner_len_reg;

    assign batch_ok = (32'(s_batch) < 32'(batch_count_reg)) && (32'(s_batch) < 32'(MAX_BATCH));
    assign row_in_r = (32'(s_row) < 32'(rows_a_reg)) && (32'(s_row) < 32'(MAX_DIM));
    assign row_in_k = (32'(s_row) < 32'(nk));
    assign col_in_k = (32'(s_col) < 32'(nk));
    assign col_in_c = (32'(s_col) < 32'(cols_b_reg)) && (32'(s_col) < 32'(MAX_DIM));

    assign ok_a = batch_ok & row_in_r & col_in_k;
    assign ok_b = batch_ok & row_in_k & col_in_c;
    assign ok_c = batch_ok & row_in_r & col_in_c;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid & s_ready;
    assign last_k   = (32'(k_reg) + 32'd1 == 32'(nk));
    assign out_free = !m_valid_reg || m_ready;

    // sequencer
    always_comb begin
        state_next         = state_reg;
        k_next             = k_reg;
        a_addr_next        = a_addr_reg;
        b_addr_next        = b_addr_reg;
        err_next           = err_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_product_next     = m_product_reg;
        m_range_error_next = m_range_error_reg;
        mac_ctrl           = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_mode)
                        MODE_WR_A: begin
                            if (!ok_a) begin
                                err_next   = 1'b1;
                                state_next = ST_FINISH;
                            end
                        end
                        MODE_WR_B: begin
                            if (!ok_b) begin
                                err_next   = 1'b1;
                                state_next = ST_FINISH;
                            end
                        end
                        MODE_RD_C: begin
                            if (!ok_c) begin
                                err_next   = 1'b1;
                                state_next = ST_FINISH;
                            end else begin
                                err_next       = 1'b0;
                                mac_ctrl.clear = 1'b1;
                                k_next         = '0;
                                a_addr_next    = store_addr(s_batch, s_row, '0);
                                b_addr_next    = store_addr(s_batch, '0, s_col);
                                state_next     = (nk == '0) ? ST_FINISH : ST_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                mac_ctrl.issue = 1'b1;
                k_next         = k_reg + K_W'(1);
                a_addr_next    = a_addr_reg + ADDR_W'(1);
                b_addr_next    = b_addr_reg + ADDR_W'(MAX_DIM);
                if (last_k) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!mac_busy && out_free) begin
                    m_valid_next       = 1'b1;
                    m_product_next     = err_reg ? '0 : mac_acc;
                    m_range_error_next = err_reg;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            err_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            err_reg     <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg             <= k_next;
        a_addr_reg        <= a_addr_next;
        b_addr_reg        <= b_addr_next;
        m_product_reg     <= m_product_next;
        m_range_error_reg <= m_range_error_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_product     = m_product_reg;
    assign m_range_error = m_range_error_reg;

    bmm_store u_a_store (
        .aclk  (aclk),
        .we    (accept && (s_mode == MODE_WR_A) && ok_a),
        .waddr (store_addr(s_batch, s_row, s_col)),
        .wdata (s_value),
        .raddr (a_addr_reg),
        .rdata (a_rdata)
    );

    bmm_store u_b_store (
        .aclk  (aclk),
        .we    (accept && (s_mode == MODE_WR_B) && ok_b),
        .waddr (store_addr(s_batch, s_row, s_col)),
        .wdata (s_value),
        .raddr (b_addr_reg),
        .rdata (b_rdata)
    );

    bmm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .a_data  (a_rdata),
        .b_data  (b_rdata),
        .acc     (mac_acc),
        .busy    (mac_busy)
    );

    `BMM_ASSERT(a_err_zero_product, m_valid_reg && m_range_error_reg |-> m_product_reg == '0, "flagged request carries a non-zero product")
    `BMM_ASSERT(a_finish_waits_mac, state_reg == ST_FINISH && mac_busy |=> state_reg == ST_FINISH, "result loaded while accumulation still in flight")
    `BMM_ASSERT(a_k_in_range, state_reg == ST_RUN |-> 32'(k_reg) < 32'(nk), "inner index beyond inner length")
    `BMM_ASSERT(a_no_issue_when_idle, state_reg != ST_RUN |-> !mac_ctrl.issue, "store read issued outside the accumulation walk")

endmodule

// ===== rtl/bmm_store.sv =====
module bmm_store
    import bmm_pkg::*;
(
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [ELEM_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [ELEM_W-1:0] rdata
);

    logic [ELEM_W-1:0] mem [STORE_DEPTH];
    logic [ELEM_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bmm_mac.sv =====
module bmm_mac
    import bmm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  mac_ctrl_t         ctrl,
    input  logic [ELEM_W-1:0] a_data,
    input  logic [ELEM_W-1:0] b_data,
    output logic [ACC_W-1:0]  acc,
    output logic              busy
);

    logic                     rd_v_reg;
    logic                     prod_v_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;

    // store read data lands in the cycle after the address is issued, marked by rd_v_reg
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
        end else begin
            rd_v_reg   <= ctrl.issue;
            prod_v_reg <= rd_v_reg;
        end
    end

    always_comb begin
        prod_next = $signed(a_data) * $signed(b_data);
        acc_next  = acc_reg;
        if (ctrl.clear) begin
            acc_next = '0;
        end else if (prod_v_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_v_reg) begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    assign acc  = acc_reg;
    assign busy = rd_v_reg | prod_v_reg;

endmodule
